// ===== design/sdcp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdcp_pkg: shared types and constants of the serial disk command port.
// Field widths, protocol codes and the bundle passed from front to back.
// ----------------------------------------------------------------------------
package sdcp_pkg;

    localparam int SECTOR_BYTES      = 128;
    localparam int SECTORS_PER_TRACK = 32;
    localparam int RESPONSE_DEPTH    = 256;
    localparam int PTR_W             = $clog2(RESPONSE_DEPTH + 1);
    localparam int ADDR_W            = $clog2(RESPONSE_DEPTH);
    localparam int CNT_W             = $clog2(SECTOR_BYTES + 1);
    localparam int SPT_W             = $clog2(SECTORS_PER_TRACK + 1);
    localparam int IDX_W             = 20;
    localparam int CAP_W             = 21;
    localparam int FULL_IDX_W        = 15 + SPT_W + 1;

    localparam logic [1:0] MODE_READ    = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_STORAGE = 2'd2;

    localparam logic [1:0] PORT_DATA   = 2'd0;
    localparam logic [1:0] PORT_STATUS = 2'd2;

    localparam logic [1:0] KIND_BUS   = 2'd0;
    localparam logic [1:0] KIND_RDREQ = 2'd1;
    localparam logic [1:0] KIND_WRB   = 2'd2;

    localparam logic [1:0] REG_ATTACHED = 2'd0;
    localparam logic [1:0] REG_RDONLY   = 2'd1;
    localparam logic [1:0] REG_CAP0     = 2'd2;
    localparam logic [1:0] REG_CAP1     = 2'd3;

    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_W    = 8'h57;
    localparam logic [7:0] FILL_B  = 8'hE5;
    localparam logic [7:0] STAT_B  = 8'h04;
    localparam logic [7:0] OTHER_B = 8'hFF;

    // Operations that the front hands to the back.
    typedef enum logic [2:0] {
        OP_POP    = 3'd0,
        OP_STATUS = 3'd1,
        OP_OTHER  = 3'd2,
        OP_RDREQ  = 3'd3,
        OP_WRB    = 3'd4,
        OP_FILL   = 3'd5,
        OP_PUSH   = 3'd6
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       value;
        logic             unit;
        logic [IDX_W-1:0] sector_index;
        logic [6:0]       byte_index;
        logic             last;
    } cmd_t;

endpackage

// ===== design/sdcp_front.sv =====
// ----------------------------------------------------------------------------
// sdcp_front: protocol parser.
// Accepts bus and storage transfers, tracks the command protocol and
// classifies each transfer into one operation for the back end.
// ----------------------------------------------------------------------------
module sdcp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [1:0]            port_offset,
    input  logic [7:0]            data,
    input  logic [1:0]            attached_mask,
    input  logic [1:0]            read_only_mask,
    input  logic [sdcp_pkg::CAP_W-1:0] cap0,
    input  logic [sdcp_pkg::CAP_W-1:0] cap1,
    input  logic                  q_full,
    output logic                  q_push,
    output sdcp_pkg::cmd_t        q_cmd
);
    import sdcp_pkg::*;

    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_PREFIX = 9'b000000010,
        PH_RD_HI  = 9'b000000100,
        PH_RD_LO  = 9'b000001000,
        PH_RD_SEC = 9'b000010000,
        PH_WR_HI  = 9'b000100000,
        PH_WR_LO  = 9'b001000000,
        PH_WR_SEC = 9'b010000000,
        PH_WR_DAT = 9'b100000000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              unit_reg, unit_next;
    logic [6:0]        thi_reg, thi_next;
    logic [14:0]       track_reg, track_next;
    logic [IDX_W-1:0]  sidx_reg, sidx_next;
    logic [CNT_W-1:0]  wcnt_reg, wcnt_next;
    logic              wperm_reg, wperm_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;

    logic                  acc;
    logic [FULL_IDX_W-1:0] full_idx;
    logic [CAP_W-1:0]      cap;
    logic                  idx_ok;
    logic                  attached;
    logic                  rdonly;

    assign in_stall = q_full;
    assign acc      = in_valid && !q_full;

    // Sector index from the stored track and the incoming sector byte.
    assign full_idx = FULL_IDX_W'(track_reg) * FULL_IDX_W'(SECTORS_PER_TRACK)
                    + FULL_IDX_W'(data);
    assign cap      = unit_reg ? cap1 : cap0;
    assign idx_ok   = (full_idx < FULL_IDX_W'(1 << IDX_W))
                    && ({{(CAP_W > FULL_IDX_W ? 0 : FULL_IDX_W - CAP_W){1'b0}}, cap}
                        > FULL_IDX_W'(full_idx)) ;
    assign attached = attached_mask[unit_reg];
    assign rdonly   = read_only_mask[unit_reg];

    // Parser and classification.
    always_comb
    begin
        phase_next = phase_reg;
        unit_next  = unit_reg;
        thi_next   = thi_reg;
        track_next = track_reg;
        sidx_next  = sidx_reg;
        wcnt_next  = wcnt_reg;
        wperm_next = wperm_reg;
        pend_next  = pend_reg;
        q_push     = 1'b0;
        q_cmd      = '0;
        q_cmd.op   = OP_OTHER;
        if (acc) begin
            case (mode)
                MODE_READ:
                begin
                    q_push = 1'b1;
                    if (port_offset == PORT_DATA)
                        q_cmd.op = OP_POP;
                    else if (port_offset == PORT_STATUS)
                        q_cmd.op = OP_STATUS;
                    else
                        q_cmd.op = OP_OTHER;
                end
                MODE_STORAGE:
                begin
                    if (pend_reg != '0) begin
                        q_push      = 1'b1;
                        q_cmd.op    = OP_PUSH;
                        q_cmd.value = data;
                        pend_next   = pend_reg - 1'b1;
                    end
                end
                MODE_WRITE:
                begin
                    if (port_offset == PORT_DATA) begin
                        unique case (phase_reg)
                            PH_IDLE:
                                if (data == CH_AT) phase_next = PH_PREFIX;
                            PH_PREFIX:
                                if (data == CH_R)      phase_next = PH_RD_HI;
                                else if (data == CH_W) phase_next = PH_WR_HI;
                                else                   phase_next = PH_IDLE;
                            PH_RD_HI, PH_WR_HI:
                            begin
                                thi_next   = data[6:0];
                                unit_next  = data[7];
                                phase_next = (phase_reg == PH_RD_HI) ? PH_RD_LO : PH_WR_LO;
                            end
                            PH_RD_LO, PH_WR_LO:
                            begin
                                track_next = {thi_reg, data};
                                phase_next = (phase_reg == PH_RD_LO) ? PH_RD_SEC : PH_WR_SEC;
                            end
                            PH_RD_SEC:
                            begin
                                sidx_next  = full_idx[IDX_W-1:0];
                                phase_next = PH_IDLE;
                                q_push     = 1'b1;
                                if (attached && idx_ok) begin
                                    pend_next          = CNT_W'(SECTOR_BYTES);
                                    q_cmd.op           = OP_RDREQ;
                                    q_cmd.unit         = unit_reg;
                                    q_cmd.sector_index = full_idx[IDX_W-1:0];
                                end else begin
                                    q_cmd.op = OP_FILL;
                                end
                            end
                            PH_WR_SEC:
                            begin
                                sidx_next  = full_idx[IDX_W-1:0];
                                wperm_next = attached && !rdonly && idx_ok;
                                wcnt_next  = '0;
                                phase_next = PH_WR_DAT;
                            end
                            PH_WR_DAT:
                            begin
                                if (wperm_reg) begin
                                    q_push             = 1'b1;
                                    q_cmd.op           = OP_WRB;
                                    q_cmd.value        = data;
                                    q_cmd.unit         = unit_reg;
                                    q_cmd.sector_index = sidx_reg;
                                    q_cmd.byte_index   = wcnt_reg[6:0];
                                    q_cmd.last = (wcnt_reg == CNT_W'(SECTOR_BYTES - 1));
                                end
                                wcnt_next = wcnt_reg + 1'b1;
                                if (wcnt_reg == CNT_W'(SECTOR_BYTES - 1))
                                    phase_next = PH_IDLE;
                            end
                            default: phase_next = PH_IDLE;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            unit_reg  <= 1'b0;
            thi_reg   <= '0;
            track_reg <= '0;
            sidx_reg  <= '0;
            wcnt_reg  <= '0;
            wperm_reg <= 1'b0;
            pend_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            unit_reg  <= unit_next;
            thi_reg   <= thi_next;
            track_reg <= track_next;
            sidx_reg  <= sidx_next;
            wcnt_reg  <= wcnt_next;
            wperm_reg <= wperm_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ===== design/sdcp_queue.sv =====
// ----------------------------------------------------------------------------
// sdcp_queue: two-entry command queue between front and back.
// Full only when both entries hold commands, so the front can keep going.
// ----------------------------------------------------------------------------
module sdcp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sdcp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output sdcp_pkg::cmd_t head
);
    import sdcp_pkg::*;

    cmd_t       slot_reg [2];
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rd_reg];

    // Pointer and count update.
    always_comb
    begin
        rd_next  = pop ? ~rd_reg : rd_reg;
        wr_next  = push ? ~wr_reg : wr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_cmd;
    end

endmodule

// ===== design/sdcp_back.sv =====
// ----------------------------------------------------------------------------
// sdcp_back: executes queued commands.
// Owns the response buffer, drives the output register and runs the
// background 0xE5 fill after a failed read.
// ----------------------------------------------------------------------------
module sdcp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_not_empty,
    input  sdcp_pkg::cmd_t             q_head,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 kind,
    output logic [7:0]                 value,
    output logic                       unit,
    output logic [sdcp_pkg::IDX_W-1:0] sector_index,
    output logic [6:0]                 byte_index,
    output logic                       last
);
    import sdcp_pkg::*;

    logic [7:0]       mem [RESPONSE_DEPTH];
    logic [PTR_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] drain_reg, drain_next;
    logic [CNT_W-1:0] efill_reg, efill_next;

    // Pending pop: read data comes from the registered memory port.
    logic             popw_reg, popw_next;
    logic [7:0]       rdata_reg;

    logic             ov_reg, ov_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       val_reg, val_next;
    logic             unit_reg, unit_next;
    logic [IDX_W-1:0] sidx_reg, sidx_next;
    logic [6:0]       bidx_reg, bidx_next;
    logic             last_reg, last_next;

    logic             out_free;
    logic             busy_fill;
    logic             do_wr;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             do_rd;
    logic [ADDR_W-1:0] rd_addr;
    logic             has_data;

    assign out_free  = !ov_reg || !out_stall;
    assign busy_fill = (efill_reg != '0);
    assign has_data  = fill_reg > drain_reg;

    // Command execution. The fill stalls everything until it is done,
    // and a pop waits for its registered memory read.
    always_comb
    begin
        fill_next  = fill_reg;
        drain_next = drain_reg;
        efill_next = efill_reg;
        popw_next  = 1'b0;
        ov_next    = ov_reg && out_stall;
        kind_next  = kind_reg;
        val_next   = val_reg;
        unit_next  = unit_reg;
        sidx_next  = sidx_reg;
        bidx_next  = bidx_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        do_wr      = 1'b0;
        wr_addr    = fill_reg[ADDR_W-1:0];
        wr_data    = FILL_B;
        do_rd      = 1'b0;
        rd_addr    = drain_reg[ADDR_W-1:0];
        if (popw_reg) begin
            // Output slot was reserved when the pop was taken.
            ov_next   = 1'b1;
            kind_next = KIND_BUS;
            val_next  = rdata_reg;
            unit_next = 1'b0;
            sidx_next = '0;
            bidx_next = '0;
            last_next = 1'b0;
        end else if (busy_fill) begin
            if (fill_reg < PTR_W'(RESPONSE_DEPTH)) begin
                do_wr     = 1'b1;
                fill_next = fill_reg + 1'b1;
            end
            efill_next = efill_reg - 1'b1;
        end else if (q_not_empty && out_free) begin
            q_pop = 1'b1;
            case (q_head.op)
                OP_POP:
                begin
                    if (has_data) begin
                        do_rd     = 1'b1;
                        popw_next = 1'b1;
                        ov_next   = 1'b0;
                        if (drain_reg + 1'b1 >= fill_reg) begin
                            drain_next = '0;
                            fill_next  = '0;
                        end else begin
                            drain_next = drain_reg + 1'b1;
                        end
                    end else begin
                        ov_next   = 1'b1;
                        kind_next = KIND_BUS;
                        val_next  = '0;
                        unit_next = 1'b0;
                        sidx_next = '0;
                        bidx_next = '0;
                        last_next = 1'b0;
                    end
                end
                OP_STATUS, OP_OTHER:
                begin
                    ov_next   = 1'b1;
                    kind_next = KIND_BUS;
                    val_next  = (q_head.op == OP_STATUS) ? (STAT_B | {7'd0, has_data})
                                                         : OTHER_B;
                    unit_next = 1'b0;
                    sidx_next = '0;
                    bidx_next = '0;
                    last_next = 1'b0;
                end
                OP_RDREQ, OP_WRB:
                begin
                    ov_next   = 1'b1;
                    kind_next = (q_head.op == OP_RDREQ) ? KIND_RDREQ : KIND_WRB;
                    val_next  = q_head.value;
                    unit_next = q_head.unit;
                    sidx_next = q_head.sector_index;
                    bidx_next = q_head.byte_index;
                    last_next = q_head.last;
                end
                OP_FILL:
                    efill_next = CNT_W'(SECTOR_BYTES);
                OP_PUSH:
                begin
                    if (fill_reg < PTR_W'(RESPONSE_DEPTH)) begin
                        do_wr     = 1'b1;
                        wr_data   = q_head.value;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg  <= '0;
            drain_reg <= '0;
            efill_reg <= '0;
            popw_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            drain_reg <= drain_next;
            efill_reg <= efill_next;
            popw_reg  <= popw_next;
            ov_reg    <= ov_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        val_reg  <= val_next;
        unit_reg <= unit_next;
        sidx_reg <= sidx_next;
        bidx_reg <= bidx_next;
        last_reg <= last_next;
    end

    // Response buffer memory.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_addr] <= wr_data;
        if (do_rd)
            rdata_reg <= mem[rd_addr];
    end

    assign out_valid    = ov_reg;
    assign kind         = kind_reg;
    assign value        = val_reg;
    assign unit         = unit_reg;
    assign sector_index = sidx_reg;
    assign byte_index   = bidx_reg;
    assign last         = last_reg;

endmodule

// ===== design/serial_disk_command_port_core.sv =====
// ----------------------------------------------------------------------------
// serial_disk_command_port_core: byte-wide disk command port.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_stall    mode, port_offset, data
//   out       out_valid / out_stall  kind, value, unit, sector_index,
//                                    byte_index, last
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transfer per cycle in steady state while the queue is not full; a
// result passes through the queue entry and then the output register, and a
// data read of a queued byte also passes through the registered buffer read
// port. A failed read starts a background 0xE5 fill of up to 128 bytes during
// which the back end executes no other command; the front end stalls once
// the two-entry queue is full. Reset is asynchronous and clears all control
// state; the response buffer holds no reset value.
// ----------------------------------------------------------------------------
module serial_disk_command_port_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [1:0]  port_offset,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  value,
    output logic        unit,
    output logic [19:0] sector_index,
    output logic [6:0]  byte_index,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data
);
    import sdcp_pkg::*;

    logic [1:0]       att_reg, ro_reg;
    logic [CAP_W-1:0] cap0_reg, cap1_reg;
    logic             q_full, q_push, q_pop, q_ne;
    cmd_t             q_cmd, q_head;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            att_reg  <= '0;
            ro_reg   <= '0;
            cap0_reg <= CAP_W'(65536);
            cap1_reg <= CAP_W'(65536);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ATTACHED: att_reg  <= cfg_data[1:0];
                REG_RDONLY:   ro_reg   <= cfg_data[1:0];
                REG_CAP0:     cap0_reg <= cfg_data;
                REG_CAP1:     cap1_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sdcp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .port_offset(port_offset), .data(data),
        .attached_mask(att_reg), .read_only_mask(ro_reg),
        .cap0(cap0_reg), .cap1(cap1_reg),
        .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd)
    );

    sdcp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(q_cmd),
        .full(q_full), .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    sdcp_back u_back (
        .clk(clk), .rst_n(rst_n), .q_not_empty(q_ne), .q_head(q_head),
        .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .value(value), .unit(unit), .sector_index(sector_index),
        .byte_index(byte_index), .last(last)
    );

endmodule

// ===== dv/sdcp_checker.sv =====
// ----------------------------------------------------------------------------
// sdcp_checker: result predictor and scoreboard for the disk command port.
// Watches the configuration, input and output channels. Each accepted input
// is run through a cycle-free model of the command parser and the response
// buffer. Every expected result is queued and compared, field by field,
// with the results that the block delivers.
// ----------------------------------------------------------------------------
module sdcp_checker
    import sdcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [1:0]  port_offset,
    input  logic [7:0]  data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  value,
    input  logic        unit,
    input  logic [19:0] sector_index,
    input  logic [6:0]  byte_index,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data,
    output int          pending,
    output int          errors
);

    typedef enum logic [3:0] {
        PARSE_IDLE, PARSE_PREFIX, PARSE_RD_HI, PARSE_RD_LO, PARSE_RD_SEC,
        PARSE_WR_HI, PARSE_WR_LO, PARSE_WR_SEC, PARSE_WR_DATA
    } parse_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic        unit;
        logic [19:0] sector_index;
        logic [6:0]  byte_index;
        logic        last;
    } port_result_t;

    // Configuration copy.
    logic [1:0]  attached_units;
    logic [1:0]  locked_units;
    logic [20:0] capacity [2];

    // Parser and buffer state.
    parse_t      parse_phase;
    logic        sel_unit;
    logic [7:0]  upper_byte;
    int          track_num;
    int          sector_num;
    int          bytes_written;
    logic        write_ok;
    int          storage_bytes_due;
    logic [7:0]  reply_bytes [RESPONSE_DEPTH];
    int          fill_ptr;
    int          drain_ptr;

    port_result_t expected_results [$];

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int linear_sector();
        return track_num * SECTORS_PER_TRACK + sector_num;
    endfunction

    function automatic logic sector_in_range();
        int idx;
        idx = linear_sector();
        return idx < (1 << IDX_W) && idx < int'(capacity[sel_unit]);
    endfunction

    function automatic void queue_reply(input logic [7:0] b);
        if (fill_ptr < RESPONSE_DEPTH)
        begin
            reply_bytes[fill_ptr] = b;
            fill_ptr++;
        end
    endfunction

    function automatic logic [7:0] take_reply();
        logic [7:0] b;
        b = 8'h00;
        if (drain_ptr < fill_ptr)
        begin
            b = reply_bytes[drain_ptr];
            drain_ptr++;
            if (drain_ptr >= fill_ptr)
            begin
                drain_ptr = 0;
                fill_ptr = 0;
            end
        end
        return b;
    endfunction

    function automatic void expect_result(input logic [1:0] k, input logic [7:0] v,
                                          input logic addressed, input int bidx,
                                          input logic lst);
        port_result_t r;
        r.kind         = k;
        r.value        = v;
        r.unit         = addressed ? sel_unit : 1'b0;
        r.sector_index = addressed ? IDX_W'(linear_sector()) : '0;
        r.byte_index   = 7'(bidx);
        r.last         = lst;
        expected_results.push_back(r);
    endfunction

    // Command parser: one bus byte written to the data port.
    function automatic void parse_byte(input logic [7:0] d);
        case (parse_phase)
            PARSE_IDLE:
                if (d == CH_AT) parse_phase = PARSE_PREFIX;
            PARSE_PREFIX:
                if (d == CH_R) parse_phase = PARSE_RD_HI;
                else if (d == CH_W) parse_phase = PARSE_WR_HI;
                else parse_phase = PARSE_IDLE;
            PARSE_RD_HI, PARSE_WR_HI:
            begin
                upper_byte = d;
                sel_unit = d[7];
                parse_phase = (parse_phase == PARSE_RD_HI) ? PARSE_RD_LO : PARSE_WR_LO;
            end
            PARSE_RD_LO, PARSE_WR_LO:
            begin
                track_num = {upper_byte[6:0], d};
                parse_phase = (parse_phase == PARSE_RD_LO) ? PARSE_RD_SEC : PARSE_WR_SEC;
            end
            PARSE_RD_SEC:
            begin
                sector_num = d;
                if (attached_units[sel_unit] && sector_in_range())
                begin
                    storage_bytes_due = SECTOR_BYTES;
                    expect_result(KIND_RDREQ, 8'h00, 1'b1, 0, 1'b0);
                end
                else
                begin
                    for (int i = 0; i < SECTOR_BYTES; i++) queue_reply(FILL_B);
                end
                parse_phase = PARSE_IDLE;
            end
            PARSE_WR_SEC:
            begin
                sector_num = d;
                write_ok = attached_units[sel_unit] && !locked_units[sel_unit]
                           && sector_in_range();
                bytes_written = 0;
                parse_phase = PARSE_WR_DATA;
            end
            PARSE_WR_DATA:
            begin
                if (write_ok)
                    expect_result(KIND_WRB, d, 1'b1, bytes_written % 128,
                                  bytes_written + 1 >= SECTOR_BYTES);
                bytes_written++;
                if (bytes_written >= SECTOR_BYTES) parse_phase = PARSE_IDLE;
            end
            default:
                parse_phase = PARSE_IDLE;
        endcase
    endfunction

    // One accepted input transfer.
    function automatic void predict_transfer(input logic [1:0] m, input logic [1:0] p,
                                             input logic [7:0] d);
        logic [7:0] v;
        case (m)
            MODE_READ:
            begin
                if (p == PORT_DATA) v = take_reply();
                else if (p == PORT_STATUS) v = STAT_B | 8'(fill_ptr > drain_ptr);
                else v = OTHER_B;
                expect_result(KIND_BUS, v, 1'b0, 0, 1'b0);
            end
            MODE_WRITE:
                if (p == PORT_DATA) parse_byte(d);
            MODE_STORAGE:
                if (storage_bytes_due > 0)
                begin
                    queue_reply(d);
                    storage_bytes_due--;
                end
            default:
                ;
        endcase
    endfunction

    // Compare the delivered result before predicting this edge's input.
    always @(posedge clk or negedge rst_n)
    begin
        port_result_t exp_r;
        if (!rst_n)
        begin
            attached_units    = '0;
            locked_units      = '0;
            capacity[0]       = 21'd65536;
            capacity[1]       = 21'd65536;
            parse_phase       = PARSE_IDLE;
            sel_unit          = 1'b0;
            upper_byte        = '0;
            track_num         = 0;
            sector_num        = 0;
            bytes_written     = 0;
            write_ok          = 1'b0;
            storage_bytes_due = 0;
            fill_ptr          = 0;
            drain_ptr         = 0;
            errors            = 0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report($sformatf("unexpected result kind %0d value %02h", kind, value));
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (kind !== exp_r.kind)
                        report($sformatf("kind %0d, expected %0d", kind, exp_r.kind));
                    if (value !== exp_r.value)
                        report($sformatf("value %02h, expected %02h", value, exp_r.value));
                    if (unit !== exp_r.unit)
                        report($sformatf("unit %0d, expected %0d", unit, exp_r.unit));
                    if (sector_index !== exp_r.sector_index)
                        report($sformatf("sector_index %0d, expected %0d",
                                         sector_index, exp_r.sector_index));
                    if (byte_index !== exp_r.byte_index)
                        report($sformatf("byte_index %0d, expected %0d",
                                         byte_index, exp_r.byte_index));
                    if (last !== exp_r.last)
                        report($sformatf("last %0d, expected %0d", last, exp_r.last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ATTACHED: attached_units = cfg_data[1:0];
                    REG_RDONLY:   locked_units   = cfg_data[1:0];
                    REG_CAP0:     capacity[0]    = cfg_data;
                    REG_CAP1:     capacity[1]    = cfg_data;
                endcase
            end
            if (in_valid && !in_stall)
                predict_transfer(mode, port_offset, data);
            pending <= expected_results.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the serial disk command port.
// Drives directed corner cases, then random read and write commands with
// their storage and data bytes, under random input gaps and output stalls,
// across several register settings. Checking is done by sdcp_checker.
// ----------------------------------------------------------------------------
module tb;
    import sdcp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = '0;
    logic [1:0]  port_offset = '0;
    logic [7:0]  data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        unit;
    logic [19:0] sector_index;
    logic [6:0]  byte_index;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [20:0] cfg_data = '0;
    int          pending;
    int          errors;

    int          burst_left = 0;
    int          items_sent = 0;
    int          stall_run = 0;
    int          stall_style = 0;

    serial_disk_command_port_core dut (.*);
    sdcp_checker checker_i (.*);

    // Clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Output stall pattern: runs of no stall, light stall and heavy stall.
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_style = $urandom_range(0, 2);
            stall_run = $urandom_range(5, 60);
        end
        stall_run--;
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // One input transfer, sent in bursts with random gaps.
    task automatic put(input logic [1:0] m, input logic [1:0] p, input logic [7:0] d);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        mode        <= m;
        port_offset <= p;
        data        <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // Hold off the sender until every expected result has arrived.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers change only once the block is idle, fill included.
    task automatic set_config(input logic [1:0] att, input logic [1:0] ro,
                              input logic [20:0] cap0, input logic [20:0] cap1);
        wait_for_results();
        repeat (300) @(negedge clk);
        write_reg(REG_ATTACHED, 21'(att));
        write_reg(REG_RDONLY, 21'(ro));
        write_reg(REG_CAP0, cap0);
        write_reg(REG_CAP1, cap1);
    endtask

    task automatic command(input logic [7:0] op, input logic [7:0] hi,
                           input logic [7:0] lo, input logic [7:0] sec);
        put(MODE_WRITE, PORT_DATA, CH_AT);
        put(MODE_WRITE, PORT_DATA, op);
        put(MODE_WRITE, PORT_DATA, hi);
        put(MODE_WRITE, PORT_DATA, lo);
        put(MODE_WRITE, PORT_DATA, sec);
    endtask

    function automatic logic [7:0] pick_upper_byte();
        logic [7:0] hi;
        hi[7] = $urandom_range(0, 1);
        hi[6:0] = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 2));
        return hi;
    endfunction

    function automatic logic [20:0] pick_capacity();
        case ($urandom_range(0, 4))
            0: return 21'd0;
            1: return 21'd1048576;
            2: return 21'd65536;
            3: return 21'($urandom_range(1, 4000));
            default: return 21'($urandom_range(0, 1048576));
        endcase
    endfunction

    task automatic read_sequence();
        int pops;
        command(CH_R, pick_upper_byte(), 8'($urandom), 8'($urandom_range(0, 40)));
        for (int i = 0; i < SECTOR_BYTES; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                put(MODE_READ, $urandom_range(0, 1) ? PORT_DATA : PORT_STATUS, 8'($urandom));
            put(MODE_STORAGE, 2'($urandom), 8'($urandom));
        end
        pops = $urandom_range(0, 140);
        for (int i = 0; i < pops; i++)
            put(MODE_READ, ($urandom_range(0, 9) == 0) ? PORT_STATUS : PORT_DATA,
                8'($urandom));
    endtask

    task automatic write_sequence();
        command(CH_W, pick_upper_byte(), 8'($urandom), 8'($urandom_range(0, 40)));
        for (int i = 0; i < SECTOR_BYTES; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                put(MODE_WRITE, PORT_STATUS, 8'($urandom));
            put(MODE_WRITE, PORT_DATA, 8'($urandom));
        end
    endtask

    task automatic noise();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
            put(2'($urandom), 2'($urandom), ($urandom_range(0, 3) == 0) ? CH_AT : 8'($urandom));
    endtask

    // Stimulus.
    initial
    begin
        int phase;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corner cases under reset configuration: nothing attached.
        put(MODE_READ, PORT_STATUS, 8'h00);
        put(MODE_READ, PORT_DATA, 8'h00);
        put(MODE_READ, 2'd1, 8'h00);
        put(MODE_READ, 2'd3, 8'hFF);
        put(2'd3, PORT_DATA, 8'hFF);
        put(MODE_WRITE, PORT_STATUS, CH_AT);
        put(MODE_STORAGE, PORT_DATA, 8'h5A);
        put(MODE_WRITE, PORT_DATA, CH_AT);
        put(MODE_WRITE, PORT_DATA, 8'h00);
        command(CH_R, 8'hFF, 8'hFF, 8'hFF);
        command(CH_R, 8'h00, 8'h00, 8'h00);
        command(CH_R, 8'h80, 8'h01, 8'h02);
        put(MODE_READ, PORT_STATUS, 8'h00);
        put(MODE_READ, PORT_DATA, 8'h00);

        // Drain the full buffer, then read past its end.
        wait_for_results();
        for (int i = 0; i < RESPONSE_DEPTH + 2; i++)
            put(MODE_READ, PORT_DATA, 8'h00);

        set_config(2'b11, 2'b00, 21'd1048576, 21'd1048576);
        phase = 0;
        while (items_sent < 900)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: read_sequence();
                4, 5, 6: write_sequence();
                7: command(CH_R, 8'hFF, 8'hFF, 8'($urandom));
                8: noise();
                default: wait_for_results();
            endcase
            if (items_sent > 250 * (phase + 1))
            begin
                phase++;
                case (phase % 4)
                    1: set_config(2'b01, 2'b11, 21'd0, 21'd1);
                    2: set_config(2'b10, 2'b01, pick_capacity(), pick_capacity());
                    3: set_config(2'($urandom), 2'($urandom), pick_capacity(), 21'd65536);
                    default: set_config(2'b11, 2'b10, 21'd1048576, pick_capacity());
                endcase
            end
        end

        wait_for_results();
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit.
    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
